@@ rtl/tvi_pkg.sv @@
// Shared types, constants and helpers for the trilinear voxel interpolation core.
// No dependencies; used by tvi_lane, tvi_merge, the top level and the bench.
package tvi_pkg;

	localparam int COORD_W       = 28;
	localparam int VOX_W         = 32;
	localparam int DIM_W         = 13;
	localparam int KIND_W        = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int AXES          = 3;
	localparam int LANES         = 8;
	localparam int DIM_MAX_DEF   = 4096;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_U8  = 3'd0,
		KIND_S8  = 3'd1,
		KIND_U16 = 3'd2,
		KIND_S16 = 3'd3,
		KIND_S32 = 3'd4
	} voxel_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_KIND   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} lane_en_t;

	typedef struct packed {
		logic s5;
		logic s6;
		logic s7;
	} merge_en_t;

	function automatic logic signed [VOX_W-1:0] decode_voxel(
		input logic [VOX_W-1:0]  raw,
		input logic [KIND_W-1:0] kind
	);
		logic signed [VOX_W-1:0] v;
		case (kind)
			KIND_U8:  v = $signed(VOX_W'(raw[7:0]));
			KIND_S8:  v = VOX_W'($signed(raw[7:0]));
			KIND_U16: v = $signed(VOX_W'(raw[15:0]));
			KIND_S16: v = VOX_W'($signed(raw[15:0]));
			default:  v = $signed(raw);
		endcase
		return v;
	endfunction

	function automatic logic kind_known(input logic [KIND_W-1:0] kind);
		return kind <= KIND_W'(KIND_S32);
	endfunction

endpackage

@@ rtl/tvi_lane.sv @@
// One corner lane: voxel value times the product of its three axis weights.
// Depends on tvi_pkg; three pipeline stages, each gated by its stage enable.
module tvi_lane #(
	parameter int FRAC_BITS = tvi_pkg::FRAC_BITS_DEF
) (
	input  logic                                            clk,
	input  tvi_pkg::lane_en_t                               en,
	input  logic signed [tvi_pkg::VOX_W-1:0]                vox,
	input  logic [FRAC_BITS:0]                              wd,
	input  logic [FRAC_BITS:0]                              ww,
	input  logic [FRAC_BITS:0]                              wh,
	output logic signed [tvi_pkg::VOX_W+3*FRAC_BITS:0]      term
);

	localparam int WT_W   = FRAC_BITS + 1;
	localparam int A_W    = tvi_pkg::VOX_W + WT_W;
	localparam int B_W    = 2 * WT_W;
	localparam int P_W    = A_W + WT_W + 1;
	localparam int TERM_W = tvi_pkg::VOX_W + 3 * FRAC_BITS + 1;

	logic signed [A_W:0]        a_full;
	logic [B_W-1:0]             b_full;
	logic signed [A_W-1:0]      a_s2;
	logic [B_W-1:0]             b_s2;
	logic signed [P_W-1:0]      plo_full;
	logic signed [P_W-1:0]      phi_full;
	logic signed [P_W-1:0]      plo_s3;
	logic signed [P_W-1:0]      phi_s3;
	logic signed [P_W+WT_W:0]   t_full;
	logic signed [TERM_W-1:0]   term_s4;

	assign a_full   = vox * $signed({1'b0, wh});
	assign b_full   = wd * ww;
	assign plo_full = a_s2 * $signed({1'b0, b_s2[WT_W-1:0]});
	assign phi_full = a_s2 * $signed({1'b0, b_s2[B_W-1:WT_W]});
	assign t_full   = (phi_s3 <<< WT_W) + plo_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2 <= $signed(a_full[A_W-1:0]);
			b_s2 <= b_full;
		end
		if (en.s3) begin
			plo_s3 <= plo_full;
			phi_s3 <= phi_full;
		end
		if (en.s4) begin
			term_s4 <= $signed(t_full[TERM_W-1:0]);
		end
	end

	assign term = term_s4;

endmodule

@@ rtl/tvi_merge.sv @@
// Registered adder tree that sums the eight lane terms in three stages.
// Depends on tvi_pkg for the lane count and stage enables.
module tvi_merge #(
	parameter int FRAC_BITS = tvi_pkg::FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  tvi_pkg::merge_en_t                          en,
	input  logic signed [tvi_pkg::VOX_W+3*FRAC_BITS:0]  term [tvi_pkg::LANES],
	output logic signed [tvi_pkg::VOX_W+3*FRAC_BITS:0]  sum
);

	localparam int TERM_W = tvi_pkg::VOX_W + 3 * FRAC_BITS + 1;

	logic signed [TERM_W-1:0] sum_s5 [4];
	logic signed [TERM_W-1:0] sum_s6 [2];
	logic signed [TERM_W-1:0] sum_s7;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int i = 0; i < 4; i++) begin
				sum_s5[i] <= term[2*i] + term[2*i+1];
			end
		end
		if (en.s6) begin
			for (int i = 0; i < 2; i++) begin
				sum_s6[i] <= sum_s5[2*i] + sum_s5[2*i+1];
			end
		end
		if (en.s7) begin
			sum_s7 <= sum_s6[0] + sum_s6[1];
		end
	end

	assign sum = sum_s7;

endmodule

@@ rtl/trilinear_voxel_interpolation_core.sv @@
// Top level of the trilinear voxel interpolation core: config registers, range
// check, weight setup, eight tvi_lane instances, tvi_merge and output stage.
// Depends on tvi_pkg, tvi_lane and tvi_merge.
//
//  channel | handshake            | word contents
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | three coordinates, eight raw corner voxels
//  out     | out_valid / out_ready| sample_value, in_range
//  config  | wr_en (no wait)      | wr_index, wr_data
//
// One word per cycle sustained while out_ready is high; eight register stages (decode,
// three lane multiply stages, three adder-tree stages, output).
// Each stage advances whenever the next one is empty or advancing, so bubbles
// close up while out_ready is low. Reset clears valid bits and config registers.
module trilinear_voxel_interpolation_core #(
	parameter int DIM_MAX   = tvi_pkg::DIM_MAX_DEF,
	parameter int FRAC_BITS = tvi_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [tvi_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [tvi_pkg::CFG_DATA_W-1:0]         wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tvi_pkg::COORD_W-1:0]     depth_coord,
	input  logic signed [tvi_pkg::COORD_W-1:0]     width_coord,
	input  logic signed [tvi_pkg::COORD_W-1:0]     height_coord,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_000,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_001,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_010,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_011,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_100,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_101,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_110,
	input  logic [tvi_pkg::VOX_W-1:0]              corner_111,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tvi_pkg::VOX_W-1:0]       sample_value,
	output logic                                   in_range
);

	localparam int STAGES = 8;
	localparam int WT_W   = FRAC_BITS + 1;
	localparam int IP_W   = tvi_pkg::COORD_W - 1 - FRAC_BITS;
	localparam int CMP_W  = (IP_W + 1 > 18) ? IP_W + 1 : 18;
	localparam int TERM_W = tvi_pkg::VOX_W + 3 * FRAC_BITS + 1;
	localparam int SH     = 3 * FRAC_BITS;
	localparam logic [WT_W-1:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CMP_W-1:0]  LIM_MAX = CMP_W'(DIM_MAX);
	localparam logic [TERM_W-1:0] RND     = {{(TERM_W-SH){1'b0}}, {SH{1'b1}}};

	typedef struct packed {
		logic ok;
		logic zero;
	} flag_t;

	logic [tvi_pkg::DIM_W-1:0]  dim_q [tvi_pkg::AXES];
	logic [tvi_pkg::KIND_W-1:0] kind_q;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;

	logic [tvi_pkg::COORD_W-1:0] coord [tvi_pkg::AXES];
	logic [tvi_pkg::VOX_W-1:0]   corner [tvi_pkg::LANES];
	logic [tvi_pkg::AXES-1:0]    axis_ok;
	logic [WT_W-1:0]             wlo [tvi_pkg::AXES];
	logic [WT_W-1:0]             whi [tvi_pkg::AXES];

	logic signed [tvi_pkg::VOX_W-1:0] vox_s1 [tvi_pkg::LANES];
	logic [WT_W-1:0]                  wlo_s1 [tvi_pkg::AXES];
	logic [WT_W-1:0]                  whi_s1 [tvi_pkg::AXES];
	flag_t flag_s1, flag_s2, flag_s3, flag_s4, flag_s5, flag_s6, flag_s7;

	logic signed [TERM_W-1:0] term [tvi_pkg::LANES];
	logic signed [TERM_W-1:0] sum_s7;
	logic signed [TERM_W-1:0] adj;
	logic signed [TERM_W-1:0] shr;

	logic signed [tvi_pkg::VOX_W-1:0] sample_s8;
	logic                             in_range_s8;

	tvi_pkg::lane_en_t  lane_en;
	tvi_pkg::merge_en_t merge_en;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < tvi_pkg::AXES; a++) begin
				dim_q[a] <= '0;
			end
			kind_q <= tvi_pkg::KIND_W'(tvi_pkg::KIND_U8);
		end else if (wr_en) begin
			case (wr_index)
				tvi_pkg::REG_DEPTH:  dim_q[0] <= wr_data[tvi_pkg::DIM_W-1:0];
				tvi_pkg::REG_WIDTH:  dim_q[1] <= wr_data[tvi_pkg::DIM_W-1:0];
				tvi_pkg::REG_HEIGHT: dim_q[2] <= wr_data[tvi_pkg::DIM_W-1:0];
				tvi_pkg::REG_KIND:   kind_q   <= wr_data[tvi_pkg::KIND_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: advance when the next stage is empty or advancing
	always_comb begin
		en[STAGES] = !vld_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign coord[0] = depth_coord;
	assign coord[1] = width_coord;
	assign coord[2] = height_coord;

	assign corner[0] = corner_000;
	assign corner[1] = corner_001;
	assign corner[2] = corner_010;
	assign corner[3] = corner_011;
	assign corner[4] = corner_100;
	assign corner[5] = corner_101;
	assign corner[6] = corner_110;
	assign corner[7] = corner_111;

	// range check and axis weights
	always_comb begin
		logic [CMP_W-1:0] lim;
		logic [CMP_W-1:0] up;
		for (int a = 0; a < tvi_pkg::AXES; a++) begin
			lim = (CMP_W'(dim_q[a]) > LIM_MAX) ? LIM_MAX : CMP_W'(dim_q[a]);
			up  = CMP_W'(coord[a][tvi_pkg::COORD_W-2:FRAC_BITS]) + CMP_W'(1);
			axis_ok[a] = !coord[a][tvi_pkg::COORD_W-1] && (up < lim);
			whi[a] = {1'b0, coord[a][FRAC_BITS-1:0]};
			wlo[a] = ONE - {1'b0, coord[a][FRAC_BITS-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < tvi_pkg::LANES; i++) begin
				vox_s1[i] <= tvi_pkg::decode_voxel(corner[i], kind_q);
			end
			for (int a = 0; a < tvi_pkg::AXES; a++) begin
				wlo_s1[a] <= wlo[a];
				whi_s1[a] <= whi[a];
			end
			flag_s1.ok   <= &axis_ok;
			flag_s1.zero <= !(&axis_ok) || !tvi_pkg::kind_known(kind_q);
		end
		if (en[2]) flag_s2 <= flag_s1;
		if (en[3]) flag_s3 <= flag_s2;
		if (en[4]) flag_s4 <= flag_s3;
		if (en[5]) flag_s5 <= flag_s4;
		if (en[6]) flag_s6 <= flag_s5;
		if (en[7]) flag_s7 <= flag_s6;
	end

	assign lane_en.s2  = en[2];
	assign lane_en.s3  = en[3];
	assign lane_en.s4  = en[4];
	assign merge_en.s5 = en[5];
	assign merge_en.s6 = en[6];
	assign merge_en.s7 = en[7];

	for (genvar i = 0; i < tvi_pkg::LANES; i++) begin : g_lane
		localparam bit SEL_D = ((i / 4) % 2) == 1;
		localparam bit SEL_W = ((i / 2) % 2) == 1;
		localparam bit SEL_H = (i % 2) == 1;
		tvi_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk  (clk),
			.en   (lane_en),
			.vox  (vox_s1[i]),
			.wd   (SEL_D ? whi_s1[0] : wlo_s1[0]),
			.ww   (SEL_W ? whi_s1[1] : wlo_s1[1]),
			.wh   (SEL_H ? whi_s1[2] : wlo_s1[2]),
			.term (term[i])
		);
	end

	tvi_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk  (clk),
		.en   (merge_en),
		.term (term),
		.sum  (sum_s7)
	);

	// truncate toward zero: bias negative sums before the arithmetic shift
	assign adj = sum_s7 + $signed(sum_s7[TERM_W-1] ? RND : '0);
	assign shr = adj >>> SH;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			sample_s8   <= flag_s7.zero ? '0 : $signed(shr[tvi_pkg::VOX_W-1:0]);
			in_range_s8 <= flag_s7.ok;
		end
	end

	assign out_valid    = vld_q[STAGES];
	assign sample_value = sample_s8;
	assign in_range     = in_range_s8;

endmodule

@@ rtl/tvi_checker.sv @@
// Port-level checker for the trilinear voxel interpolation core, bound to the top.
// Depends only on the top level's ports.
module tvi_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [31:0]      sample_value,
	input logic                    in_range
);

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_value) && $stable(in_range)))
		else $error("output word changed or dropped while stalled");

	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (sample_value == 32'sd0))
		else $error("out-of-range word carries a nonzero sample");

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !out_valid) |-> in_ready)
		else $error("input stalled with an empty output stage");

endmodule

bind trilinear_voxel_interpolation_core tvi_checker u_tvi_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for trilinear_voxel_interpolation_core: directed and random
// words under many register settings, results predicted in-bench and compared in order.
// Depends on tvi_pkg and the core RTL only.
module tb;

	localparam int FRAC           = tvi_pkg::FRAC_BITS_DEF;
	localparam int DIM_LIMIT      = tvi_pkg::DIM_MAX_DEF;
	localparam int COORD_W        = tvi_pkg::COORD_W;
	localparam int VOX_W          = tvi_pkg::VOX_W;
	localparam int LANES          = tvi_pkg::LANES;
	localparam int AXES           = tvi_pkg::AXES;
	localparam int DIM_W          = tvi_pkg::DIM_W;
	localparam int KIND_W         = tvi_pkg::KIND_W;
	localparam int CFG_IDX_W      = tvi_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W     = tvi_pkg::CFG_DATA_W;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 24;

	typedef struct packed {
		logic [COORD_W-1:0]            depth;
		logic [COORD_W-1:0]            width;
		logic [COORD_W-1:0]            height;
		logic [LANES-1:0][VOX_W-1:0]   corner;
	} voxel_word_t;

	typedef struct packed {
		logic signed [VOX_W-1:0] sample;
		logic                    in_range;
	} sample_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]          wr_index = '0;
	logic [CFG_DATA_W-1:0]         wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic signed [COORD_W-1:0]     depth_coord = '0;
	logic signed [COORD_W-1:0]     width_coord = '0;
	logic signed [COORD_W-1:0]     height_coord = '0;
	logic [VOX_W-1:0]              corner_000 = '0;
	logic [VOX_W-1:0]              corner_001 = '0;
	logic [VOX_W-1:0]              corner_010 = '0;
	logic [VOX_W-1:0]              corner_011 = '0;
	logic [VOX_W-1:0]              corner_100 = '0;
	logic [VOX_W-1:0]              corner_101 = '0;
	logic [VOX_W-1:0]              corner_110 = '0;
	logic [VOX_W-1:0]              corner_111 = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [VOX_W-1:0]       sample_value;
	logic                          in_range;

	logic [DIM_W-1:0]  vol_depth_q = '0;
	logic [DIM_W-1:0]  vol_width_q = '0;
	logic [DIM_W-1:0]  vol_height_q = '0;
	logic [KIND_W-1:0] voxel_kind_q = '0;

	voxel_word_t    pending_words[$];
	sample_result_t expected_samples[$];
	voxel_word_t    cur_word;
	bit             hold_send = 1'b0;
	bit             send_quiet = 1'b0;
	bit             recv_quiet = 1'b0;
	int             send_gap = 0;
	int             recv_gap = 0;
	int             quiet_cycles = 0;
	int             mismatch_count = 0;
	int             sample_count = 0;
	int             hit_count = 0;
	int             setting_count = 0;

	trilinear_voxel_interpolation_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.depth_coord  (depth_coord),
		.width_coord  (width_coord),
		.height_coord (height_coord),
		.corner_000   (corner_000),
		.corner_001   (corner_001),
		.corner_010   (corner_010),
		.corner_011   (corner_011),
		.corner_100   (corner_100),
		.corner_101   (corner_101),
		.corner_110   (corner_110),
		.corner_111   (corner_111),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_value (sample_value),
		.in_range     (in_range)
	);

	always #2 clk = ~clk;

	function automatic sample_result_t interpolate(voxel_word_t w);
		sample_result_t          r;
		logic [COORD_W-1:0]      crd[AXES];
		logic [DIM_W-1:0]        dims[AXES];
		logic [FRAC-1:0]         fr[AXES];
		logic signed [32:0]      v;
		logic signed [127:0]     acc;
		logic signed [127:0]     term;
		logic signed [127:0]     wt;
		logic [VOX_W-1:0]        raw;
		bit                      ok;
		int                      sat;
		int                      ip;
		crd[0] = w.depth;
		crd[1] = w.width;
		crd[2] = w.height;
		dims[0] = vol_depth_q;
		dims[1] = vol_width_q;
		dims[2] = vol_height_q;
		ok = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			sat = (dims[a] > DIM_LIMIT) ? DIM_LIMIT : int'(dims[a]);
			ip = int'(crd[a][COORD_W-2:FRAC]);
			fr[a] = crd[a][FRAC-1:0];
			if (crd[a][COORD_W-1] || ip + 1 >= sat)
				ok = 1'b0;
		end
		r.in_range = ok;
		r.sample = '0;
		if (!ok || voxel_kind_q > tvi_pkg::KIND_S32)
			return r;
		acc = '0;
		for (int i = 0; i < LANES; i++) begin
			raw = w.corner[i];
			case (voxel_kind_q)
				tvi_pkg::KIND_U8:  v = {25'd0, raw[7:0]};
				tvi_pkg::KIND_S8:  v = {{25{raw[7]}}, raw[7:0]};
				tvi_pkg::KIND_U16: v = {17'd0, raw[15:0]};
				tvi_pkg::KIND_S16: v = {{17{raw[15]}}, raw[15:0]};
				default:           v = {raw[31], raw};
			endcase
			term = v;
			for (int a = 0; a < AXES; a++) begin
				if (((i >> (AXES - 1 - a)) & 1) != 0)
					wt = fr[a];
				else
					wt = (17'd1 << FRAC) - {1'b0, fr[a]};
				term = term * wt;
			end
			acc = acc + term;
		end
		if (acc < 0) begin
			acc = -acc;
			acc = acc >> (3 * FRAC);
			acc = -acc;
		end else begin
			acc = acc >> (3 * FRAC);
		end
		r.sample = acc[VOX_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : driver
		bit fire;
		bit v_next;
		fire = in_valid && in_ready;
		if (fire)
			expected_samples.push_back(interpolate(cur_word));
		v_next = in_valid && !fire;
		if (!v_next) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (!hold_send && pending_words.size() > 0) begin
				cur_word = pending_words.pop_front();
				depth_coord  <= cur_word.depth;
				width_coord  <= cur_word.width;
				height_coord <= cur_word.height;
				corner_000   <= cur_word.corner[0];
				corner_001   <= cur_word.corner[1];
				corner_010   <= cur_word.corner[2];
				corner_011   <= cur_word.corner[3];
				corner_100   <= cur_word.corner[4];
				corner_101   <= cur_word.corner[5];
				corner_110   <= cur_word.corner[6];
				corner_111   <= cur_word.corner[7];
				v_next = 1'b1;
				send_gap = pick_gap(send_quiet);
			end
		end
		in_valid <= v_next;
	end

	always @(posedge clk) begin : monitor
		sample_result_t want;
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected word: expected none, actual sample_value %0d in_range %0b",
					$time, sample_value, in_range);
			end else begin
				want = expected_samples.pop_front();
				sample_count++;
				if (want.in_range)
					hit_count++;
				if (sample_value !== want.sample) begin
					mismatch_count++;
					$display("%0t sample_value mismatch: expected %0d, actual %0d",
						$time, want.sample, sample_value);
				end
				if (in_range !== want.in_range) begin
					mismatch_count++;
					$display("%0t in_range mismatch: expected %0b, actual %0b",
						$time, want.in_range, in_range);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				recv_gap = pick_gap(recv_quiet);
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input tvi_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			tvi_pkg::REG_DEPTH:  vol_depth_q  = val[DIM_W-1:0];
			tvi_pkg::REG_WIDTH:  vol_width_q  = val[DIM_W-1:0];
			tvi_pkg::REG_HEIGHT: vol_height_q = val[DIM_W-1:0];
			tvi_pkg::REG_KIND:   voxel_kind_q = val[KIND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int d, input int w, input int h,
			input logic [CFG_DATA_W-1:0] kind_word);
		wait_idle();
		write_reg(tvi_pkg::REG_DEPTH, CFG_DATA_W'(d));
		write_reg(tvi_pkg::REG_WIDTH, CFG_DATA_W'(w));
		write_reg(tvi_pkg::REG_HEIGHT, CFG_DATA_W'(h));
		write_reg(tvi_pkg::REG_KIND, kind_word);
		setting_count++;
	endtask

	function automatic logic [COORD_W-1:0] fix(int ip, int frac);
		return {ip[COORD_W-FRAC-1:0], frac[FRAC-1:0]};
	endfunction

	task automatic push_word(input logic [COORD_W-1:0] d, input logic [COORD_W-1:0] w,
			input logic [COORD_W-1:0] h, input logic [LANES-1:0][VOX_W-1:0] c);
		voxel_word_t vw;
		vw.depth  = d;
		vw.width  = w;
		vw.height = h;
		vw.corner = c;
		pending_words.push_back(vw);
	endtask

	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(0, 1);
		if (r < 50)
			return $urandom_range(2, 16);
		if (r < 70)
			return $urandom_range(17, 300);
		if (r < 85)
			return DIM_LIMIT;
		return $urandom_range(DIM_LIMIT + 1, (1 << DIM_W) - 1);
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int dim);
		int sat;
		int r;
		int frac;
		sat = (dim > DIM_LIMIT) ? DIM_LIMIT : dim;
		r = $urandom_range(0, 99);
		frac = $urandom_range(0, (1 << FRAC) - 1);
		if ($urandom_range(0, 9) == 0)
			frac = 0;
		else if ($urandom_range(0, 9) == 0)
			frac = (1 << FRAC) - 1;
		if (sat >= 2 && r < 85)
			return fix($urandom_range(0, sat - 2), frac);
		if (r < 90)
			return {1'b1, (COORD_W-1)'($urandom)};
		if (r < 95)
			return fix(sat - 1 + $urandom_range(0, 1), frac);
		return COORD_W'($urandom);
	endfunction

	function automatic logic [VOX_W-1:0] pick_corner();
		logic [VOX_W-1:0] edges[10];
		edges = '{32'h0, 32'h7F, 32'h80, 32'hFF, 32'h7FFF, 32'h8000, 32'hFFFF,
			32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};
		if ($urandom_range(0, 4) == 0)
			return edges[$urandom_range(0, 9)];
		return $urandom;
	endfunction

	task automatic queue_random(input int n);
		logic [LANES-1:0][VOX_W-1:0] c;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < LANES; i++)
				c[i] = pick_corner();
			push_word(pick_coord(vol_depth_q), pick_coord(vol_width_q),
				pick_coord(vol_height_q), c);
		end
	endtask

	initial begin : stimulus
		int d;
		int w;
		int h;
		int kind;
		arst_n <= 1'b0;
		send_quiet = 1'b1;
		recv_quiet = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(2, 3, 4, CFG_DATA_W'(tvi_pkg::KIND_S8));
		push_word(fix(0, 0), fix(0, 0), fix(0, 0), {8{32'h80}});
		push_word(fix(0, 16'hFFFF), fix(1, 16'hFFFF), fix(2, 16'hFFFF), {8{32'h7F}});
		push_word(fix(0, 16'h8000), fix(0, 16'h8000), fix(0, 16'h8000),
			{{4{32'h80}}, {4{32'h7F}}});
		push_word(fix(1, 0), fix(0, 0), fix(0, 0), {8{32'h7F}});
		push_word(fix(0, 0), 28'hFFFFFFF, fix(0, 0), {8{32'h7F}});
		push_word(fix(0, 0), fix(0, 0), 28'h8000000, {8{32'h7F}});
		push_word(28'h7FFFFFF, fix(0, 0), fix(0, 0), {8{32'h7F}});
		push_word(fix(0, 16'h1234), fix(1, 16'hABCD), fix(2, 16'h0001),
			{32'hDEADBEEF, 32'h12345678, 32'hFFFFFF80, 32'h0000007F,
			32'hA5A5A5A5, 32'h5A5A5A5A, 32'h80000001, 32'h7FFFFFFE});
		set_config(2, 3, 4, CFG_DATA_W'(tvi_pkg::KIND_U8));
		push_word(fix(0, 16'h4000), fix(1, 16'hC000), fix(1, 16'h2000),
			{{4{32'hFFFFFFFF}}, {4{32'h000000FF}}});
		set_config(2, 2, 2, CFG_DATA_W'(tvi_pkg::KIND_U16));
		push_word(fix(0, 16'hFFFF), fix(0, 1), fix(0, 16'h8001), {8{32'hFFFFFFFF}});
		push_word(fix(0, 16'h00FF), fix(0, 16'hFF00), fix(0, 16'h0F0F), {8{32'h00008000}});
		set_config(2, 2, 2, CFG_DATA_W'(tvi_pkg::KIND_S16));
		push_word(fix(0, 0), fix(0, 16'hFFFF), fix(0, 0), {8{32'hFFFF8000}});
		push_word(fix(0, 1), fix(0, 1), fix(0, 1),
			{32'h7FFF, 32'h8000, 32'h7FFF, 32'h8000, 32'h7FFF, 32'h8000, 32'h7FFF, 32'h8000});
		set_config((1 << DIM_W) - 1, DIM_LIMIT + 1, DIM_LIMIT, CFG_DATA_W'(tvi_pkg::KIND_S32));
		push_word(fix(4094, 16'hFFFF), fix(4094, 16'hFFFF), fix(4094, 16'hFFFF),
			{8{32'h80000000}});
		push_word(fix(4095, 0), fix(0, 0), fix(0, 0), {8{32'h7FFFFFFF}});
		push_word(fix(100, 16'h3333), fix(2000, 16'hCCCC), fix(4094, 16'h8000),
			{{4{32'h7FFFFFFF}}, {4{32'h80000000}}});
		set_config(1, 0, 2, CFG_DATA_W'(tvi_pkg::KIND_U16));
		push_word(fix(0, 0), fix(0, 0), fix(0, 0), {8{32'h1234}});
		set_config(16, 16, 16, 13'h1FFF);
		push_word(fix(3, 16'h1111), fix(7, 16'h2222), fix(14, 16'hFFFF), {8{32'h55}});
		set_config(16, 16, 16, CFG_DATA_W'(5));
		push_word(fix(0, 0), fix(0, 0), fix(0, 0), {8{32'h55}});

		for (int p = 0; p < 12; p++) begin
			d = pick_dim();
			w = pick_dim();
			h = pick_dim();
			if (p < 5) begin
				kind = p;
				d = (d < 2) ? d + 2 : d;
			end else if (p == 5) begin
				kind = $urandom_range(5, 7);
			end else begin
				kind = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			end
			set_config(d, w, h, {(CFG_DATA_W-KIND_W)'($urandom), KIND_W'(kind)});
			send_quiet = (p % 4 == 1);
			recv_quiet = (p % 4 == 1) || (p % 6 == 4);
			queue_random(100);
			if (p == 3) begin
				@(negedge clk);
				while (pending_words.size() > 50)
					@(negedge clk);
				hold_send = 1'b1;
				while (in_valid || expected_samples.size() != 0)
					@(negedge clk);
				hold_send = 1'b0;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d samples, %0d of them in range, over %0d register settings,",
			sample_count, hit_count, setting_count);
		$display("with every voxel kind, unknown kinds, saturated and tiny volume sizes.");
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
